### rtl/core/usfd_pkg.sv
// ----------------------------------------------------------------------------
// usfd_pkg
// Shared types, sizes and codes of the UART status and frame demultiplexer.
// ----------------------------------------------------------------------------
package usfd_pkg;

    localparam int RX_DEPTH     = 128;
    localparam int STATUS_DEPTH = 64;
    localparam int RX_IW        = $clog2(RX_DEPTH);
    localparam int ST_IW        = $clog2(STATUS_DEPTH);

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_STATUS_DELIM = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_START  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FRAME_END    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_TRANSPARENT  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_TIMEOUT      = 3'd4;

    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_FLUSH_RX = 2'd2;
    localparam logic [1:0] OP_FLUSH_ST = 2'd3;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_STATUS_BYTE = 3'd1;
    localparam logic [2:0] EV_STATUS_DONE = 3'd2;
    localparam logic [2:0] EV_RX_BYTE     = 3'd3;
    localparam logic [2:0] EV_FRAME_DONE  = 3'd4;
    localparam logic [2:0] EV_TIMEOUT     = 3'd5;
    localparam logic [2:0] EV_FLUSHED     = 3'd6;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic       line_error;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [6:0] write_address;
        logic [7:0] write_data;
        logic [6:0] status_length;
        logic [7:0] frame_length;
        logic       transparent_busy;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  status_delimiter;
        logic [7:0]  frame_start_byte;
        logic [7:0]  frame_end_byte;
        logic        transparent_mode;
        logic [15:0] frame_timeout_reload;
    } t_cfg;

    typedef struct packed {
        logic             in_status_message;
        logic             in_frame;
        logic [RX_IW-1:0] rx_write_index;
        logic [ST_IW-1:0] status_write_index;
        logic [7:0]       frame_byte_count;
        logic             data_in_progress;
        logic [15:0]      timeout_counter;
    } t_state;

endpackage

### rtl/core/usfd_engine.sv
// ----------------------------------------------------------------------------
// usfd_engine
// Next state and result word for one input word, purely combinational.
// ----------------------------------------------------------------------------
module usfd_engine (
    input  usfd_pkg::t_state   i_state,
    input  usfd_pkg::t_cfg     i_cfg,
    input  usfd_pkg::t_in_item i_item,
    output usfd_pkg::t_state   o_state,
    output usfd_pkg::t_out_item o_result
);
    import usfd_pkg::*;

    logic [RX_IW:0]   rx_inc;
    logic [ST_IW:0]   st_inc;
    logic [RX_IW-1:0] rx_next;
    logic [ST_IW-1:0] st_next;
    logic [2:0]       ev;
    logic [6:0]       addr;
    logic [7:0]       data;
    logic [6:0]       slen;

    always_comb begin
        rx_inc  = {1'b0, i_state.rx_write_index} + 1'b1;
        st_inc  = {1'b0, i_state.status_write_index} + 1'b1;
        rx_next = (rx_inc >= (RX_IW+1)'(RX_DEPTH)) ? '0 : rx_inc[RX_IW-1:0];
        st_next = (st_inc >= (ST_IW+1)'(STATUS_DEPTH)) ? '0 : st_inc[ST_IW-1:0];
    end

    always_comb begin
        o_state = i_state;
        ev   = EV_NONE;
        addr = '0;
        data = '0;
        slen = '0;
        unique case (i_item.opcode)
            OP_BYTE: begin
                if (!i_item.line_error) begin
                    if (i_state.in_status_message) begin
                        if (i_item.rx_byte == i_cfg.status_delimiter) begin
                            o_state.in_status_message = 1'b0;
                            addr = 7'(i_state.status_write_index);
                            slen = 7'(st_inc);
                            ev   = EV_STATUS_DONE;
                        end else begin
                            o_state.status_write_index = st_next;
                            addr = 7'(i_state.status_write_index);
                            data = i_item.rx_byte;
                            ev   = EV_STATUS_BYTE;
                        end
                    end else if (i_item.rx_byte == i_cfg.status_delimiter) begin
                        o_state.in_status_message = 1'b1;
                    end else if (!i_cfg.transparent_mode) begin
                        o_state.rx_write_index = rx_next;
                        addr = 7'(i_state.rx_write_index);
                        data = i_item.rx_byte;
                        ev   = EV_RX_BYTE;
                    end else begin
                        o_state.data_in_progress = 1'b1;
                        o_state.timeout_counter  = i_cfg.frame_timeout_reload;
                        if (!i_state.in_frame) begin
                            if (i_item.rx_byte == i_cfg.frame_start_byte) begin
                                o_state.in_frame         = 1'b1;
                                o_state.frame_byte_count = '0;
                            end
                        end else if (i_item.rx_byte == i_cfg.frame_end_byte) begin
                            o_state.in_frame = 1'b0;
                            ev = EV_FRAME_DONE;
                        end else begin
                            o_state.frame_byte_count = i_state.frame_byte_count + 8'd1;
                            o_state.rx_write_index   = rx_next;
                            addr = 7'(i_state.rx_write_index);
                            data = i_item.rx_byte;
                            ev   = EV_RX_BYTE;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (i_state.data_in_progress) begin
                    if (i_state.timeout_counter == '0) begin
                        o_state.data_in_progress = 1'b0;
                        o_state.in_frame         = 1'b0;
                        o_state.rx_write_index   = '0;
                        ev = EV_TIMEOUT;
                    end else begin
                        o_state.timeout_counter = i_state.timeout_counter - 16'd1;
                    end
                end
            end
            OP_FLUSH_RX: begin
                o_state.rx_write_index = '0;
                ev = EV_FLUSHED;
            end
            OP_FLUSH_ST: begin
                o_state.status_write_index = '0;
                ev = EV_FLUSHED;
            end
        endcase
    end

    always_comb begin
        o_result.event_res        = ev;
        o_result.write_address    = addr;
        o_result.write_data       = data;
        o_result.status_length    = slen;
        o_result.frame_length     = o_state.frame_byte_count;
        o_result.transparent_busy = o_state.data_in_progress;
    end

endmodule

### rtl/core/uart_status_and_frame_demux_core.sv
// ----------------------------------------------------------------------------
// uart_status_and_frame_demux_core
// Splits received UART bytes into status messages, receive buffer writes and
// transparent-mode frames, and emits buffer write addresses.
//
//   Channel   Signals                              Moves
//   input     i_valid, o_stall, i_data             one byte, tick or flush word
//   output    o_valid, i_stall, o_data             one result word per input
//   config    i_cfg_we, i_cfg_idx, i_cfg_data      one register write
//
// Each input word updates the state in the cycle it is accepted; its result
// is registered in the result queue, so one word per cycle is sustained while i_stall is low.
// A two-entry result queue lets one word be accepted while a result waits;
// o_stall rises only when both entries are full.
// Synchronous active-low reset clears the state, empties the queue and loads the configuration defaults.
// ----------------------------------------------------------------------------
module uart_status_and_frame_demux_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  usfd_pkg::t_in_item             i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output usfd_pkg::t_out_item            o_data,
    input  logic                           i_cfg_we,
    input  logic [usfd_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [usfd_pkg::CFG_DW-1:0]    i_cfg_data
);
    import usfd_pkg::*;

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_result;
    t_out_item r_q [2];
    logic      r_head;
    logic [1:0] r_cnt;
    logic      push;
    logic      pop;
    logic      tail;

    usfd_engine u_engine (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (i_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_head];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign tail    = r_head ^ r_cnt[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_delimiter     <= 8'd37;
            r_cfg.frame_start_byte     <= 8'd2;
            r_cfg.frame_end_byte       <= 8'd3;
            r_cfg.transparent_mode     <= 1'b0;
            r_cfg.frame_timeout_reload <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATUS_DELIM: r_cfg.status_delimiter     <= i_cfg_data[7:0];
                CFG_FRAME_START:  r_cfg.frame_start_byte     <= i_cfg_data[7:0];
                CFG_FRAME_END:    r_cfg.frame_end_byte       <= i_cfg_data[7:0];
                CFG_TRANSPARENT:  r_cfg.transparent_mode     <= i_cfg_data[0];
                CFG_TIMEOUT:      r_cfg.frame_timeout_reload <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_head  <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (push) begin
                r_state <= n_state;
            end
            if (pop) begin
                r_head <= ~r_head;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[tail] <= n_result;
        end
    end

endmodule

### rtl/core/usfd_checker.sv
// ----------------------------------------------------------------------------
// usfd_checker
// Port-level checks of the demultiplexer, bound to the top level.
// ----------------------------------------------------------------------------
module usfd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  usfd_pkg::t_out_item            o_data
);
    import usfd_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Result queue not empty after reset.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("Stalled result changed.");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("Accepted word produced no result.");

    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.event_res == EV_STATUS_DONE |->
            o_data.write_data == 8'd0 &&
            o_data.status_length == o_data.write_address + 7'd1)
        else $error("Status completion word is inconsistent.");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.event_res == EV_NONE || o_data.event_res == EV_FLUSHED ||
            o_data.event_res == EV_TIMEOUT || o_data.event_res == EV_FRAME_DONE) |->
            o_data.write_address == 7'd0 && o_data.write_data == 8'd0 &&
            o_data.status_length == 7'd0)
        else $error("Non-write event carries write fields.");

endmodule

bind uart_status_and_frame_demux_core usfd_checker u_usfd_checker (.*);
